// ----- hdl/ookd_pkg.sv -----
// Shared types, constants and codes of the pulse-width remote decoder.
// Used by every module in hdl/ through scoped names; depends on nothing.
package ookd_pkg;

    // Sizing of the capture store and the frame
    localparam int STORE_DEPTH      = 128;
    localparam int DATA_BITS        = 24;
    localparam int FRAME_TIMEOUT_US = 5000;
    localparam int REPEAT_DELAY_MS  = 500;

    localparam int ADDR_W    = $clog2(STORE_DEPTH);
    localparam int CNT_W     = $clog2(STORE_DEPTH + 1);
    localparam int BITS_W    = $clog2(DATA_BITS + 1);
    localparam int DUR_W     = 16;
    localparam int CODE_W    = 24;
    localparam int EDGES_W   = 8;
    localparam int TIME_W    = 32;
    localparam int MIN_FRAME = 2 + 2 * DATA_BITS;
    localparam int SHORT_CAP = DATA_BITS / 2;

    localparam logic [DUR_W-1:0]  FRAME_TIMEOUT = DUR_W'(FRAME_TIMEOUT_US);
    localparam logic [TIME_W-1:0] REPEAT_DELAY  = TIME_W'(REPEAT_DELAY_MS);

    // Configuration port
    localparam int NUM_REGS = 8;
    localparam int REG_W    = 16;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    typedef enum logic [2:0] {
        REG_SYNC_HIGH_MIN = 3'd0,
        REG_SYNC_HIGH_MAX = 3'd1,
        REG_SYNC_LOW_MIN  = 3'd2,
        REG_SYNC_LOW_MAX  = 3'd3,
        REG_SHORT_MIN     = 3'd4,
        REG_SHORT_MAX     = 3'd5,
        REG_LONG_MIN      = 3'd6,
        REG_LONG_MAX      = 3'd7
    } t_reg_idx;

    localparam logic [REG_W-1:0] CFG_RESET [NUM_REGS] = '{
        16'd200, 16'd600, 16'd8000, 16'd14000, 16'd200, 16'd600, 16'd800, 16'd1500
    };

    // Input word kinds
    typedef enum logic [1:0] {
        KIND_EDGE = 2'd0,
        KIND_POLL = 2'd1,
        KIND_TAKE = 2'd2
    } t_kind;

    typedef struct packed {
        logic [1:0]        kind;
        logic [DUR_W-1:0]  duration_us;
        logic [DUR_W-1:0]  idle_us;
        logic [TIME_W-1:0] now_ms;
    } t_in;

    typedef struct packed {
        logic               new_code;
        logic [CODE_W-1:0]  code;
        logic [EDGES_W-1:0] stored_edges;
    } t_out;

    // Timing windows as seen by the decoder
    typedef struct packed {
        logic [REG_W-1:0] sync_high_min;
        logic [REG_W-1:0] sync_high_max;
        logic [REG_W-1:0] sync_low_min;
        logic [REG_W-1:0] sync_low_max;
        logic [REG_W-1:0] short_min;
        logic [REG_W-1:0] short_max;
        logic [REG_W-1:0] long_min;
        logic [REG_W-1:0] long_max;
    } t_cfg;

    // Window hits of one duration
    typedef struct packed {
        logic sync_hi;
        logic sync_lo;
        logic short_p;
        logic long_p;
    } t_win;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_EV,
        S_HI_RD,
        S_HI_EV,
        S_LO_RD,
        S_LO_EV,
        S_COMMIT,
        S_REPORT
    } t_state;

endpackage

// ----- hdl/ookd_cfg.sv -----
// Configuration register file with an APB-style slave port.
// Uses ookd_pkg for register count, reset values and the t_cfg bundle.
module ookd_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ookd_pkg::PADDR_W-1:0]  paddr,
    input  logic [ookd_pkg::PDATA_W-1:0]  pwdata,
    output logic [ookd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output ookd_pkg::t_cfg                o_cfg
);

    logic [ookd_pkg::REG_W-1:0] r_regs [ookd_pkg::NUM_REGS];
    logic [2:0]                 reg_sel;

    assign reg_sel = paddr[ookd_pkg::PADDR_W-1:2];
    assign pready  = 1'b1;

    // Write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ookd_pkg::NUM_REGS; k++) begin
                r_regs[k] <= ookd_pkg::CFG_RESET[k];
            end
        end else if (psel && penable && pwrite) begin
            r_regs[reg_sel] <= pwdata[ookd_pkg::REG_W-1:0];
        end
    end

    // Read back the addressed register
    assign prdata = ookd_pkg::PDATA_W'(r_regs[reg_sel]);

    // Bundle the windows
    assign o_cfg.sync_high_min = r_regs[ookd_pkg::REG_SYNC_HIGH_MIN];
    assign o_cfg.sync_high_max = r_regs[ookd_pkg::REG_SYNC_HIGH_MAX];
    assign o_cfg.sync_low_min  = r_regs[ookd_pkg::REG_SYNC_LOW_MIN];
    assign o_cfg.sync_low_max  = r_regs[ookd_pkg::REG_SYNC_LOW_MAX];
    assign o_cfg.short_min     = r_regs[ookd_pkg::REG_SHORT_MIN];
    assign o_cfg.short_max     = r_regs[ookd_pkg::REG_SHORT_MAX];
    assign o_cfg.long_min      = r_regs[ookd_pkg::REG_LONG_MIN];
    assign o_cfg.long_max      = r_regs[ookd_pkg::REG_LONG_MAX];

endmodule

// ----- hdl/ookd_store.sv -----
// Capture store of edge durations: one write port, one registered read port.
// Uses ookd_pkg for depth and widths; contents undefined until written.
module ookd_store (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [ookd_pkg::ADDR_W-1:0]  i_waddr,
    input  logic [ookd_pkg::DUR_W-1:0]   i_wdata,
    input  logic [ookd_pkg::ADDR_W-1:0]  i_raddr,
    output logic [ookd_pkg::DUR_W-1:0]   o_rdata
);

    logic [ookd_pkg::DUR_W-1:0] mem [ookd_pkg::STORE_DEPTH];
    logic [ookd_pkg::DUR_W-1:0] r_rdata;

    // Store a duration
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read every cycle
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/ookd_win.sv -----
// Shared window compare unit: checks one duration against all four windows.
// Uses ookd_pkg for t_cfg and t_win.
module ookd_win (
    input  logic [ookd_pkg::DUR_W-1:0] i_dur,
    input  ookd_pkg::t_cfg             i_cfg,
    output ookd_pkg::t_win             o_win
);

    // Inclusive bounds on every window
    assign o_win.sync_hi = (i_dur >= i_cfg.sync_high_min) && (i_dur <= i_cfg.sync_high_max);
    assign o_win.sync_lo = (i_dur >= i_cfg.sync_low_min)  && (i_dur <= i_cfg.sync_low_max);
    assign o_win.short_p = (i_dur >= i_cfg.short_min)     && (i_dur <= i_cfg.short_max);
    assign o_win.long_p  = (i_dur >= i_cfg.long_min)      && (i_dur <= i_cfg.long_max);

endmodule

// ----- hdl/ook_remote_pulse_decoder.sv -----
// Pulse-width remote-control frame decoder, top level.
// Uses ookd_pkg and instantiates ookd_cfg, ookd_store and ookd_win.
//
// Input channel (i_in_valid / o_in_stall / i_in_word) carries one word per
// event: an edge with its duration, a poll with idle time and millisecond
// clock, or a take that clears the new-code flag. Every accepted word yields
// exactly one output word (o_out_valid / i_out_stall / o_out_word) holding
// the new-code flag, the last accepted code and the number of stored edges.
// Edge, take and polls that do not scan go through the report state to the
// output register, and no new word is accepted until the state is idle. A
// poll that scans the store walks it with one window compare unit and one
// registered read port, reading and then evaluating each stored duration.
// The input stalls while a word is in work and while a finished output word is
// held by a stalled receiver; an output word holds until taken. Reset clears
// the count, code, flag and repeat history and loads the timing windows with
// their defaults; the store needs no clearing pass. The user must write the
// timing windows through the APB port only while the block is idle; the block does not enforce it.
module ook_remote_pulse_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ookd_pkg::t_in                 i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ookd_pkg::t_out                o_out_word,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ookd_pkg::PADDR_W-1:0]  paddr,
    input  logic [ookd_pkg::PDATA_W-1:0]  pwdata,
    output logic [ookd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int CNT_W  = ookd_pkg::CNT_W;
    localparam int CODE_W = ookd_pkg::CODE_W;
    localparam int BITS_W = ookd_pkg::BITS_W;
    localparam int TIME_W = ookd_pkg::TIME_W;

    ookd_pkg::t_cfg   cfg;
    ookd_pkg::t_win   win;
    ookd_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]             r_count, n_count;
    logic [CNT_W-1:0]             r_n, n_n;
    logic [CNT_W-1:0]             r_idx, n_idx;
    logic [CODE_W-1:0]            r_code, n_code;
    logic                         r_flag, n_flag;
    logic [CODE_W-1:0]            r_prev_code, n_prev_code;
    logic [TIME_W-1:0]            r_prev_time, n_prev_time;
    logic [TIME_W-1:0]            r_now, n_now;
    logic                         r_prev_sh, n_prev_sh;
    ookd_pkg::t_win               r_hi_win, n_hi_win;
    logic [CODE_W-1:0]            r_value, n_value;
    logic [BITS_W-1:0]            r_bits, n_bits;
    logic                         r_out_valid;
    ookd_pkg::t_out               r_out_word;

    logic                         in_acc;
    logic                         out_load;
    logic                         st_we;
    logic [ookd_pkg::DUR_W-1:0]   rdata;
    logic [CNT_W:0]               idx_inc;
    logic                         at_end;
    logic                         pair_zero;
    logic                         pair_one;
    logic [TIME_W-1:0]            elapsed;

    // Register file
    ookd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Capture store, read at the scan index
    ookd_store u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_count[ookd_pkg::ADDR_W-1:0]),
        .i_wdata (i_in_word.duration_us),
        .i_raddr (r_idx[ookd_pkg::ADDR_W-1:0]),
        .o_rdata (rdata)
    );

    // Window compare on the word just read
    ookd_win u_win (
        .i_dur (rdata),
        .i_cfg (cfg),
        .o_win (win)
    );

    // Handshake
    assign o_in_stall  = (r_state != ookd_pkg::S_IDLE) || (r_out_valid && i_out_stall);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Scan helpers
    assign idx_inc   = {1'b0, r_idx} + (CNT_W + 1)'(1);
    assign at_end    = idx_inc >= {1'b0, r_n};
    assign pair_zero = r_hi_win.short_p && win.long_p;
    assign pair_one  = r_hi_win.long_p && win.short_p;
    assign elapsed   = r_now - r_prev_time;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ookd_pkg::S_IDLE;
            r_count     <= '0;
            r_code      <= '0;
            r_flag      <= 1'b0;
            r_prev_code <= '0;
            r_prev_time <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_code      <= n_code;
            r_flag      <= n_flag;
            r_prev_code <= n_prev_code;
            r_prev_time <= n_prev_time;
        end
    end

    // Scan registers
    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_idx     <= n_idx;
        r_now     <= n_now;
        r_prev_sh <= n_prev_sh;
        r_hi_win  <= n_hi_win;
        r_value   <= n_value;
        r_bits    <= n_bits;
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_code      = r_code;
        n_flag      = r_flag;
        n_prev_code = r_prev_code;
        n_prev_time = r_prev_time;
        n_n         = r_n;
        n_idx       = r_idx;
        n_now       = r_now;
        n_prev_sh   = r_prev_sh;
        n_hi_win    = r_hi_win;
        n_value     = r_value;
        n_bits      = r_bits;
        st_we       = 1'b0;
        out_load    = 1'b0;

        unique case (r_state)
            ookd_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = ookd_pkg::S_REPORT;
                    unique case (i_in_word.kind)
                        ookd_pkg::KIND_EDGE: begin
                            if (i_in_word.duration_us > ookd_pkg::FRAME_TIMEOUT) begin
                                n_count = '0;
                            end else if (r_count < CNT_W'(ookd_pkg::STORE_DEPTH)) begin
                                st_we   = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end else begin
                                n_count = '0;
                            end
                        end
                        ookd_pkg::KIND_POLL: begin
                            if (r_count != '0 &&
                                i_in_word.idle_us > ookd_pkg::FRAME_TIMEOUT) begin
                                n_count = '0;
                                n_n     = r_count;
                                if (32'(r_count) > 32'(ookd_pkg::SHORT_CAP)) begin
                                    if (32'(r_count) < 32'(ookd_pkg::MIN_FRAME)) begin
                                        n_flag = 1'b0;
                                    end else begin
                                        n_idx     = '0;
                                        n_prev_sh = 1'b0;
                                        n_now     = i_in_word.now_ms;
                                        n_state   = ookd_pkg::S_SRCH_RD;
                                    end
                                end
                            end
                        end
                        ookd_pkg::KIND_TAKE: begin
                            n_flag = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Look for the first sync pair
            ookd_pkg::S_SRCH_RD: begin
                n_state = ookd_pkg::S_SRCH_EV;
            end
            ookd_pkg::S_SRCH_EV: begin
                if (r_prev_sh && win.sync_lo) begin
                    n_idx   = idx_inc[CNT_W-1:0];
                    n_bits  = '0;
                    n_value = '0;
                    n_state = ookd_pkg::S_HI_RD;
                end else if (at_end) begin
                    n_flag  = 1'b0;
                    n_state = ookd_pkg::S_REPORT;
                end else begin
                    n_prev_sh = win.sync_hi;
                    n_idx     = idx_inc[CNT_W-1:0];
                    n_state   = ookd_pkg::S_SRCH_RD;
                end
            end

            // Decode short/long pairs
            ookd_pkg::S_HI_RD: begin
                if (r_bits == BITS_W'(ookd_pkg::DATA_BITS)) begin
                    n_state = ookd_pkg::S_COMMIT;
                end else if (at_end) begin
                    n_flag  = 1'b0;
                    n_state = ookd_pkg::S_REPORT;
                end else begin
                    n_state = ookd_pkg::S_HI_EV;
                end
            end
            ookd_pkg::S_HI_EV: begin
                n_hi_win = win;
                n_idx    = idx_inc[CNT_W-1:0];
                n_state  = ookd_pkg::S_LO_RD;
            end
            ookd_pkg::S_LO_RD: begin
                n_state = ookd_pkg::S_LO_EV;
            end
            ookd_pkg::S_LO_EV: begin
                if (pair_zero || pair_one) begin
                    n_value = {r_value[CODE_W-2:0], !pair_zero};
                    n_bits  = r_bits + BITS_W'(1);
                    n_idx   = idx_inc[CNT_W-1:0];
                    n_state = ookd_pkg::S_HI_RD;
                end else begin
                    n_flag  = 1'b0;
                    n_state = ookd_pkg::S_REPORT;
                end
            end

            // Accept the code, suppress a quick repeat
            ookd_pkg::S_COMMIT: begin
                n_code = r_value;
                if (r_value != r_prev_code || elapsed > ookd_pkg::REPEAT_DELAY) begin
                    n_flag      = 1'b1;
                    n_prev_code = r_value;
                    n_prev_time = r_now;
                end else begin
                    n_flag = 1'b0;
                end
                n_state = ookd_pkg::S_REPORT;
            end

            ookd_pkg::S_REPORT: begin
                out_load = 1'b1;
                n_state  = ookd_pkg::S_IDLE;
            end

            default: begin
                n_state = ookd_pkg::S_IDLE;
            end
        endcase
    end

    // Output word: load on report, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_word.new_code     <= r_flag;
            r_out_word.code         <= r_code;
            r_out_word.stored_edges <= ookd_pkg::EDGES_W'(r_count);
        end
    end

endmodule
